/* rtl/core/afr_pkg.sv */
// ----------------------------------------------------------------------------
// afr_pkg
// Types and constants shared by the addressed frame receiver: byte codes,
// frame phases, result kinds, reject reasons and the state and result records.
// ----------------------------------------------------------------------------
package afr_pkg;

	localparam int STORE_DEPTH = 64;
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
	localparam int CMP_W       = CNT_W + 9;
	localparam int IDX_W       = 6;
	localparam int BYTE_W      = 8;
	localparam int TDATA_W     = 16;

	localparam logic [BYTE_W-1:0] CH_STX  = 8'h02;
	localparam logic [BYTE_W-1:0] CH_ETX  = 8'h03;
	localparam logic [BYTE_W-1:0] CH_DLE  = 8'h10;
	localparam logic [BYTE_W-1:0] ESC_XOR = 8'h20;

	localparam logic [CMP_W-1:0] HEADER_LEFT = CMP_W'(2);

	typedef enum logic [6:0] {
		PH_WAIT = 7'b0000001,
		PH_DEST = 7'b0000010,
		PH_SRC  = 7'b0000100,
		PH_LEN  = 7'b0001000,
		PH_DATA = 7'b0010000,
		PH_LRC  = 7'b0100000,
		PH_END  = 7'b1000000
	} afr_phase_t;

	typedef enum logic [1:0] {
		KIND_BYTE   = 2'd0,
		KIND_ACCEPT = 2'd1,
		KIND_REJECT = 2'd2
	} afr_kind_t;

	typedef enum logic [1:0] {
		WHY_END  = 2'd0,
		WHY_LRC  = 2'd1,
		WHY_ADDR = 2'd2,
		WHY_OVF  = 2'd3
	} afr_reason_t;

	typedef struct packed {
		afr_phase_t        phase;
		logic [BYTE_W-1:0] lrc;
		logic              esc;
		logic [CNT_W-1:0]  count;
		logic [BYTE_W-1:0] dlen;
	} afr_state_t;

	typedef struct packed {
		logic              valid;
		afr_kind_t         kind;
		logic [BYTE_W-1:0] value;
		logic [IDX_W-1:0]  index;
		afr_reason_t       reason;
	} afr_result_t;

	localparam afr_state_t IDLE_STATE = '{
		phase: PH_WAIT,
		lrc:   '0,
		esc:   1'b0,
		count: '0,
		dlen:  '0
	};

endpackage

/* rtl/core/afr_decode.sv */
// ----------------------------------------------------------------------------
// afr_decode
// Next-state and result logic for one received byte: frame phase walk,
// address check, unescaping, running LRC and store overflow check.
// ----------------------------------------------------------------------------
module afr_decode (
	input  afr_pkg::afr_state_t  cur,
	input  logic [7:0]           rx_byte,
	input  logic [7:0]           station_address,
	output afr_pkg::afr_state_t  nxt,
	output afr_pkg::afr_result_t res
);
	import afr_pkg::*;

	logic              do_store;
	afr_phase_t        st_phase;
	logic [BYTE_W-1:0] st_value;
	logic              overflow;

	assign overflow = (cur.count >= CNT_W'(STORE_DEPTH));

	always_comb begin
		nxt      = cur;
		res      = '0;
		do_store = 1'b0;
		st_phase = cur.phase;
		st_value = rx_byte;
		case (cur.phase)
			PH_WAIT: begin
				nxt = IDLE_STATE;
				if (rx_byte == CH_STX) begin
					nxt.phase = PH_DEST;
				end
			end
			PH_DEST: begin
				if (rx_byte != station_address) begin
					res.valid  = 1'b1;
					res.kind   = KIND_REJECT;
					res.reason = WHY_ADDR;
					nxt        = IDLE_STATE;
				end else begin
					do_store = 1'b1;
					st_phase = PH_SRC;
				end
			end
			PH_SRC: begin
				do_store = 1'b1;
				st_phase = PH_LEN;
			end
			PH_LEN: begin
				do_store = 1'b1;
				st_phase = (rx_byte == '0) ? PH_LRC : PH_DATA;
			end
			PH_DATA: begin
				if (!cur.esc && (rx_byte inside {CH_DLE, CH_ETX, CH_STX})) begin
					nxt.esc = 1'b1;
				end else begin
					st_value = cur.esc ? (rx_byte ^ ESC_XOR) : rx_byte;
					nxt.esc  = 1'b0;
					do_store = 1'b1;
					st_phase = ((CMP_W'(cur.count) - HEADER_LEFT) == CMP_W'(cur.dlen))
						? PH_LRC : PH_DATA;
				end
			end
			PH_LRC: begin
				if (overflow) begin
					res.valid  = 1'b1;
					res.kind   = KIND_REJECT;
					res.reason = WHY_OVF;
					nxt        = IDLE_STATE;
				end else if ((cur.lrc ^ rx_byte) != '0) begin
					res.valid  = 1'b1;
					res.kind   = KIND_REJECT;
					res.reason = WHY_LRC;
					nxt        = IDLE_STATE;
				end else begin
					do_store = 1'b1;
					st_phase = PH_END;
				end
			end
			PH_END: begin
				res.valid  = 1'b1;
				res.kind   = (rx_byte == CH_ETX) ? KIND_ACCEPT : KIND_REJECT;
				res.reason = WHY_END;
				nxt        = IDLE_STATE;
			end
			default: begin
				nxt = IDLE_STATE;
			end
		endcase

		if (do_store) begin
			res.valid = 1'b1;
			if (overflow) begin
				res.kind   = KIND_REJECT;
				res.reason = WHY_OVF;
				nxt        = IDLE_STATE;
			end else begin
				res.kind  = KIND_BYTE;
				res.value = st_value;
				res.index = cur.count[IDX_W-1:0];
				nxt.lrc   = cur.lrc ^ rx_byte;
				nxt.count = cur.count + CNT_W'(1);
				nxt.phase = st_phase;
				if (cur.phase == PH_LEN) begin
					nxt.dlen = rx_byte;
				end
			end
		end
	end

endmodule

/* rtl/core/afr_out_reg.sv */
// ----------------------------------------------------------------------------
// afr_out_reg
// Result register between the decode logic and the output stream; takes a
// new result in the cycle the held one leaves.
// ----------------------------------------------------------------------------
module afr_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  afr_pkg::afr_result_t res,
	output logic                 can_load,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [15:0]          m_axis_tdata,
	output logic [1:0]           m_axis_tuser
);
	import afr_pkg::*;

	logic        valid_q;
	afr_result_t res_q;

	assign can_load = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= res.valid;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res.valid) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tuser  = res_q.kind;
	assign m_axis_tdata  = {res_q.reason, res_q.index, res_q.value};

endmodule

/* rtl/core/addressed_frame_receiver_core.sv */
// ----------------------------------------------------------------------------
// addressed_frame_receiver_core
// Receives raw serial bytes, finds STX/dest/src/len/payload/LRC/ETX frames
// addressed to this station and reports stored bytes and frame outcomes.
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one raw received byte per transfer in tdata.
//   m_axis carries at most one result per input byte: tuser is the result
//   kind (stored byte, frame accepted, frame rejected), tdata holds the
//   unescaped byte, its index in the frame and the reject reason.
//   cfg_we with cfg_wdata sets the station address; write only while idle.
// timing
//   one byte per cycle sustained while m_axis_tready stays high; a result
//   appears on m_axis in the cycle after its input transfer, from the single result register.
//   escape marks, bytes outside a frame and the start byte give no result.
// reset
//   arst_n clears the frame state to waiting for start and the station
//   address to zero; no result is pending after reset.
// stall
//   while a result is held and m_axis_tready is low, s_axis_tready is low;
//   the result register is refilled in the same cycle it is emptied.
// ----------------------------------------------------------------------------
module addressed_frame_receiver_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [7:0] byte_value, [13:8] byte_index,
	                                   // [15:14] reject_reason
	output logic [1:0]  m_axis_tuser   // [1:0] result_kind
);
	import afr_pkg::*;

	logic        [7:0] station_q;
	afr_state_t        state_q;
	afr_state_t        state_nxt;
	afr_result_t       res;
	logic              can_load;
	logic              in_fire;

	assign s_axis_tready = can_load;
	assign in_fire       = s_axis_tvalid && can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_q <= '0;
		end else if (cfg_we) begin
			station_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE_STATE;
		end else if (in_fire) begin
			state_q <= state_nxt;
		end
	end

	afr_decode u_decode (
		.cur             (state_q),
		.rx_byte         (s_axis_tdata),
		.station_address (station_q),
		.nxt             (state_nxt),
		.res             (res)
	);

	afr_out_reg u_out_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (in_fire),
		.res           (res),
		.can_load      (can_load),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

`ifndef NO_ASSERTIONS
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_WAIT) |-> (state_q.count == '0 && state_q.lrc == '0
			&& !state_q.esc))
		else $error("waiting state not cleared");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.count <= CNT_W'(STORE_DEPTH))
		else $error("stored count beyond store depth");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
		else $error("input taken while result stalled");

	a_wait_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && state_q.phase == PH_WAIT) |=> !m_axis_tvalid)
		else $error("result produced outside a frame");

	a_byte_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != KIND_BYTE) |-> (m_axis_tdata[13:0] == '0))
		else $error("frame outcome carries byte fields");
`endif

endmodule

/* test/frame_check_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_check_pkg
// Byte-level predictor and result scoreboard for the addressed frame receiver.
// Every received byte is run through a local copy of the receiver state.
// The result it gives, if any, is queued and checked in order against
// m_axis transfers.
// ----------------------------------------------------------------------------
package frame_check_pkg;

	import afr_pkg::*;

	localparam int HEADER_LEN = 3;

	typedef struct packed {
		afr_kind_t         kind;
		logic [BYTE_W-1:0] value;
		logic [IDX_W-1:0]  index;
		afr_reason_t       reason;
	} frame_result_t;

	class frame_scoreboard;

		afr_phase_t        rx_phase;
		logic [BYTE_W-1:0] lrc_acc;
		bit                esc_armed;
		int unsigned       stored_n;
		logic [BYTE_W-1:0] decl_len;
		logic [BYTE_W-1:0] station;
		frame_result_t     expected_q[$];
		int unsigned       mismatches;
		int unsigned       bytes_seen;
		int unsigned       accepts;
		int unsigned       rejects[4];

		function new();
			station = '0;
			restart();
		endfunction

		function void restart();
			rx_phase  = PH_WAIT;
			lrc_acc   = '0;
			esc_armed = 1'b0;
			stored_n  = 0;
			decl_len  = '0;
		endfunction

		function void set_address(logic [BYTE_W-1:0] addr);
			station = addr;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function frame_result_t outcome(afr_kind_t kind, afr_reason_t why);
			frame_result_t res;
			res.kind   = kind;
			res.value  = '0;
			res.index  = '0;
			res.reason = why;
			return res;
		endfunction

		// returns 0 when the store is full and the frame is dropped
		function bit store_rx(logic [BYTE_W-1:0] raw, logic [BYTE_W-1:0] val,
			output frame_result_t res);
			if (stored_n >= STORE_DEPTH) begin
				res = outcome(KIND_REJECT, WHY_OVF);
				restart();
				return 1'b0;
			end
			lrc_acc    = lrc_acc ^ raw;
			res.kind   = KIND_BYTE;
			res.value  = val;
			res.index  = IDX_W'(stored_n);
			res.reason = WHY_END;
			stored_n++;
			return 1'b1;
		endfunction

		function void note_rx_byte(logic [BYTE_W-1:0] b);
			frame_result_t     res;
			bit                produced;
			logic [BYTE_W-1:0] val;
			produced = 1'b1;
			case (rx_phase)
				PH_WAIT: begin
					restart();
					if (b == CH_STX)
						rx_phase = PH_DEST;
					produced = 1'b0;
				end
				PH_DEST: begin
					if (b != station) begin
						res = outcome(KIND_REJECT, WHY_ADDR);
						restart();
					end else if (store_rx(b, b, res)) begin
						rx_phase = PH_SRC;
					end
				end
				PH_SRC: begin
					if (store_rx(b, b, res))
						rx_phase = PH_LEN;
				end
				PH_LEN: begin
					if (store_rx(b, b, res)) begin
						decl_len = b;
						rx_phase = (b == 8'h00) ? PH_LRC : PH_DATA;
					end
				end
				PH_DATA: begin
					if (!esc_armed && (b == CH_DLE || b == CH_STX || b == CH_ETX)) begin
						esc_armed = 1'b1;
						produced  = 1'b0;
					end else begin
						val       = esc_armed ? (b ^ ESC_XOR) : b;
						esc_armed = 1'b0;
						if (store_rx(b, val, res) && stored_n - HEADER_LEN == decl_len)
							rx_phase = PH_LRC;
					end
				end
				PH_LRC: begin
					if (stored_n >= STORE_DEPTH) begin
						res = outcome(KIND_REJECT, WHY_OVF);
						restart();
					end else if ((lrc_acc ^ b) != 8'h00) begin
						res = outcome(KIND_REJECT, WHY_LRC);
						restart();
					end else if (store_rx(b, b, res)) begin
						rx_phase = PH_END;
					end
				end
				PH_END: begin
					res = outcome((b == CH_ETX) ? KIND_ACCEPT : KIND_REJECT, WHY_END);
					restart();
				end
				default: begin
					restart();
					produced = 1'b0;
				end
			endcase
			if (produced)
				expected_q.push_back(res);
		endfunction

		task report(string what);
			if (mismatches < 25)
				$display("mismatch: %s", what);
			mismatches++;
		endtask

		task check_result(logic [1:0] kind, logic [BYTE_W-1:0] value,
			logic [IDX_W-1:0] index, logic [1:0] reason);
			frame_result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result kind %0d value %02h index %0d reason %0d",
					kind, value, index, reason));
				return;
			end
			want = expected_q.pop_front();
			if (kind !== want.kind)
				report($sformatf("kind %0d, expected %0d", kind, want.kind));
			if (value !== want.value)
				report($sformatf("byte value %02h, expected %02h", value, want.value));
			if (index !== want.index)
				report($sformatf("byte index %0d, expected %0d", index, want.index));
			if (reason !== want.reason)
				report($sformatf("reject reason %0d, expected %0d", reason, want.reason));
			case (want.kind)
				KIND_BYTE:   bytes_seen++;
				KIND_ACCEPT: accepts++;
				default:     rejects[want.reason]++;
			endcase
		endtask

	endclass

endpackage

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for addressed_frame_receiver_core. Directed frames hit the
// special cases, then mostly well-formed random frames with escapes, bad
// LRCs, bad end markers, long frames and line noise run under several
// station addresses, with random gaps and stalls on both streams until the last one.
// ----------------------------------------------------------------------------
module tb;

	import afr_pkg::*;
	import frame_check_pkg::*;

	localparam int RX_TARGET   = 1200;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_we        = 1'b0;
	logic [7:0]  cfg_wdata     = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	frame_scoreboard sb;
	bit              quiet     = 1'b0;
	logic [7:0]      station   = '0;
	int unsigned     rx_sent   = 0;
	int unsigned     cycles    = 0;
	int unsigned     settings  = 0;
	logic [7:0]      payload_q[$];

	addressed_frame_receiver_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result side
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[13:8],
				m_axis_tdata[15:14]);
	end

	initial begin
		int burst;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 9);
				m_axis_tready <= 1'b0;
				repeat (burst) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	task automatic send_rx(input logic [7:0] b);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_rx_byte(b);
		rx_sent++;
		@(negedge clk);
	endtask

	// sends payload_q as the stored raw payload, escaping where needed
	task automatic send_frame(input logic [7:0] dest, input logic [7:0] src,
		input logic [7:0] decl_len, input int esc_pct, input bit bad_lrc,
		input logic [7:0] tail);
		logic [7:0] lrc;
		logic [7:0] mark;
		lrc = dest ^ src ^ decl_len;
		send_rx(CH_STX);
		send_rx(dest);
		send_rx(src);
		send_rx(decl_len);
		foreach (payload_q[i]) begin
			if (payload_q[i] == CH_DLE || payload_q[i] == CH_STX || payload_q[i] == CH_ETX ||
				$urandom_range(0, 99) < esc_pct) begin
				case ($urandom_range(0, 2))
					0:       mark = CH_DLE;
					1:       mark = CH_STX;
					default: mark = CH_ETX;
				endcase
				send_rx(mark);
			end
			send_rx(payload_q[i]);
			lrc = lrc ^ payload_q[i];
		end
		if (bad_lrc)
			lrc = lrc ^ 8'($urandom_range(1, 255));
		send_rx(lrc);
		send_rx(tail);
		payload_q.delete();
	endtask

	task automatic fill_payload(input int n);
		repeat (n) begin
			case ($urandom_range(0, 7))
				0:       payload_q.push_back(CH_DLE);
				1:       payload_q.push_back(CH_STX);
				2:       payload_q.push_back(CH_ETX);
				default: payload_q.push_back(8'($urandom));
			endcase
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_station(input logic [7:0] addr);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= addr;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.set_address(addr);
		station = addr;
		settings++;
	endtask

	task automatic random_frame();
		int         pick;
		int         n;
		logic [7:0] dest;
		logic [7:0] decl_len;
		logic [7:0] tail;
		pick = $urandom_range(0, 99);
		n = (pick < 80) ? $urandom_range(0, 12) :
			(pick < 93) ? $urandom_range(13, 40) : $urandom_range(55, 66);
		fill_payload(n);
		decl_len = 8'(n);
		// declared length at least as long as what follows
		if ($urandom_range(0, 19) == 0)
			decl_len = 8'($urandom_range(n, 255));
		dest = ($urandom_range(0, 99) < 85) ? station : 8'($urandom);
		tail = ($urandom_range(0, 99) < 88) ? CH_ETX : 8'($urandom);
		send_frame(dest, 8'($urandom), decl_len, $urandom_range(0, 30),
			$urandom_range(0, 99) < 8, tail);
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 4)) send_rx(8'($urandom));
		// truncated frame
		if ($urandom_range(0, 19) == 0) begin
			send_rx(CH_STX);
			send_rx(station);
			repeat ($urandom_range(0, 3)) send_rx(8'($urandom));
		end
	endtask

	initial begin
		int unsigned target;
		sb = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// station address 0 after reset
		send_rx(8'h00);
		send_rx(8'hFF);
		send_rx(CH_DLE);
		send_rx(CH_ETX);
		send_frame(8'h00, 8'hFF, 8'h00, 0, 1'b0, CH_ETX);
		payload_q = '{CH_DLE, CH_STX, CH_ETX, 8'h00, 8'hFF, 8'h7F, 8'h80};
		send_frame(8'h00, CH_STX, 8'd7, 0, 1'b0, CH_ETX);
		payload_q = '{8'hAA, 8'h55};
		send_frame(8'h00, 8'h11, 8'd2, 100, 1'b0, CH_ETX);
		send_frame(8'h01, 8'h22, 8'h00, 0, 1'b0, CH_ETX);
		payload_q = '{8'h11};
		send_frame(8'h00, 8'h33, 8'd1, 0, 1'b1, CH_ETX);
		send_frame(8'h00, 8'h44, 8'h00, 0, 1'b0, 8'h00);
		send_frame(8'h00, 8'h45, 8'h00, 0, 1'b0, CH_STX);
		fill_payload(60);
		send_frame(8'h00, 8'h66, 8'd60, 0, 1'b0, CH_ETX);
		fill_payload(61);
		send_frame(8'h00, 8'h77, 8'd61, 0, 1'b0, CH_ETX);
		fill_payload(62);
		send_frame(8'h00, 8'h88, 8'hFF, 0, 1'b0, CH_ETX);

		set_station(8'hFF);
		send_frame(8'hFF, 8'h01, 8'h00, 0, 1'b0, CH_ETX);
		send_frame(8'h00, 8'h01, 8'h00, 0, 1'b0, CH_ETX);

		for (int p = 0; p < 5; p++) begin
			case (p)
				0:       set_station(8'($urandom));
				1:       set_station(CH_STX);
				2:       set_station(8'h00);
				3:       set_station(8'($urandom));
				default: set_station(8'hFF);
			endcase
			if (p == 4)
				quiet = 1'b1;
			target = RX_TARGET * (p + 1) / 5;
			while (rx_sent < target)
				random_frame();
		end

		drain();
		repeat (8) @(negedge clk);

		$display("covered %0d received bytes under %0d station address settings",
			rx_sent, settings);
		$display("checked %0d stored bytes, %0d accepted frames", sb.bytes_seen, sb.accepts);
		$display("rejects end/lrc/addr/ovf %0d/%0d/%0d/%0d",
			sb.rejects[0], sb.rejects[1], sb.rejects[2], sb.rejects[3]);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* files.f */
rtl/core/afr_pkg.sv
rtl/core/afr_decode.sv
rtl/core/afr_out_reg.sv
rtl/core/addressed_frame_receiver_core.sv
test/frame_check_pkg.sv
test/tb.sv
